/* design/qstc_pkg.sv */
// shared types and constants for the smallest-three quaternion codec
package qstc_pkg;

   // fixed-point scale of one quaternion component
   localparam int unsigned COMPONENT_SCALE = 32767;
   localparam logic [15:0] SCALE_16 = 16'(COMPONENT_SCALE);
   localparam logic [14:0] SCALE_15 = 15'(COMPONENT_SCALE);

   // quantisation width register
   localparam logic [4:0] QUANT_RESET = 5'd12;
   localparam logic [4:0] QUANT_MIN   = 5'd9;
   localparam logic [4:0] QUANT_MAX   = 5'd16;

   // register index decoded from the csr address
   localparam logic REG_QUANT_BITS = 1'b0;

   // low byte forced on to form the decode scale
   localparam logic [15:0] SCALE_LOW_MASK = 16'h00ff;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } qstc_op_type;

   // per-request control travelling down the pipeline
   typedef struct packed {
      logic        valid;
      logic        op;
      logic [1:0]  qc;
      logic [14:0] s;
   } qstc_ctrl_type;

   localparam int CTRL_W = $bits(qstc_ctrl_type);

endpackage

/* design/qstc_req_if.sv */
// request and response channel interfaces of the codec
interface qstc_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [15:0] in0;
   logic signed [15:0] in1;
   logic signed [15:0] in2;
   logic signed [15:0] in3;

   modport source (output valid, opcode, in0, in1, in2, in3, input ready);
   modport sink   (input valid, opcode, in0, in1, in2, in3, output ready);
endinterface

interface qstc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out0;
   logic signed [15:0] out1;
   logic signed [15:0] out2;
   logic signed [15:0] out3;

   modport source (output valid, out0, out1, out2, out3, input ready);
   modport sink   (input valid, out0, out1, out2, out3, output ready);
endinterface

/* design/qstc_sqrt.sv */
// pipelined integer square root, one root bit per stage
module qstc_sqrt #(
   parameter int RAD_W = 64,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic [RAD_W-1:0]     rad,
   input  logic [TAG_W-1:0]     tag_in,
   output logic [RAD_W/2-1:0]   root,
   output logic [TAG_W-1:0]     tag_out
);

   localparam int ROOT_W = RAD_W / 2;

   logic [ROOT_W:0]   rem_st  [ROOT_W+1];
   logic [ROOT_W-1:0] root_st [ROOT_W+1];
   logic [RAD_W-1:0]  rad_st  [ROOT_W+1];
   logic [TAG_W-1:0]  tag_st  [ROOT_W+1];

   // stage zero straight from the inputs
   assign rem_st[0]  = '0;
   assign root_st[0] = '0;
   assign rad_st[0]  = rad;
   assign tag_st[0]  = tag_in;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      logic [ROOT_W+2:0] cat;
      logic [ROOT_W+2:0] trial;
      logic [ROOT_W+2:0] diff;
      logic              ge;
      logic [ROOT_W:0]   rem_in, rem_ff;
      logic [ROOT_W-1:0] root_in, root_ff;
      logic [RAD_W-1:0]  rad_in, rad_ff;
      logic [TAG_W-1:0]  tag_ff;

      // bring down two radicand bits and try the next root bit
      always_comb begin
         cat     = {rem_st[j], rad_st[j][RAD_W-1 -: 2]};
         trial   = {1'b0, root_st[j], 2'b01};
         diff    = cat - trial;
         ge      = (cat >= trial);
         rem_in  = ge ? diff[ROOT_W:0] : cat[ROOT_W:0];
         root_in = {root_st[j][ROOT_W-2:0], ge};
         rad_in  = {rad_st[j][RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff <= '0;
         end else if (adv) begin
            tag_ff <= tag_st[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= rad_in;
         end
      end

      assign rem_st[j+1]  = rem_ff;
      assign root_st[j+1] = root_ff;
      assign rad_st[j+1]  = rad_ff;
      assign tag_st[j+1]  = tag_ff;
   end

   assign root    = root_st[ROOT_W];
   assign tag_out = tag_st[ROOT_W];

endmodule

/* design/qstc_div.sv */
// pipelined restoring divider, one quotient bit per stage
module qstc_div #(
   parameter int QUO_W = 32,
   parameter int DEN_W = 16,
   parameter int TAG_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic [QUO_W+DEN_W-1:0] num,
   input  logic [DEN_W-1:0]       den,
   input  logic [TAG_W-1:0]       tag_in,
   output logic [QUO_W-1:0]       quo,
   output logic [TAG_W-1:0]       tag_out
);

   logic [DEN_W-1:0] rem_st [QUO_W+1];
   logic [QUO_W-1:0] low_st [QUO_W+1];
   logic [QUO_W-1:0] quo_st [QUO_W+1];
   logic [DEN_W-1:0] den_st [QUO_W+1];
   logic [TAG_W-1:0] tag_st [QUO_W+1];

   // high part of the numerator is already below the divisor
   assign rem_st[0] = num[QUO_W+DEN_W-1:QUO_W];
   assign low_st[0] = num[QUO_W-1:0];
   assign quo_st[0] = '0;
   assign den_st[0] = den;
   assign tag_st[0] = tag_in;

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [DEN_W:0]   cat;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in, rem_ff;
      logic [QUO_W-1:0] low_in, low_ff;
      logic [QUO_W-1:0] quo_in, quo_ff;
      logic [DEN_W-1:0] den_ff;
      logic [TAG_W-1:0] tag_ff;

      // shift in one numerator bit and subtract where it fits
      always_comb begin
         cat    = {rem_st[j], low_st[j][QUO_W-1]};
         diff   = cat - {1'b0, den_st[j]};
         ge     = (cat >= {1'b0, den_st[j]});
         rem_in = ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
         low_in = {low_st[j][QUO_W-2:0], 1'b0};
         quo_in = {quo_st[j][QUO_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff <= '0;
         end else if (adv) begin
            tag_ff <= tag_st[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff <= rem_in;
            low_ff <= low_in;
            quo_ff <= quo_in;
            den_ff <= den_st[j];
         end
      end

      assign rem_st[j+1] = rem_ff;
      assign low_st[j+1] = low_ff;
      assign quo_st[j+1] = quo_ff;
      assign den_st[j+1] = den_ff;
      assign tag_st[j+1] = tag_ff;
   end

   assign quo     = quo_st[QUO_W];
   assign tag_out = tag_st[QUO_W];

endmodule

/* design/quaternion_smallest_three_codec_top.sv */
// Smallest-three quaternion codec, fully pipelined from request acceptance to response valid.
// Throughput one request per cycle; the 64 root and quotient stages of the square root and
// divider units set the latency, and a stalled response freezes the whole pipeline in place.
// Reset (synchronous, active high) empties every pipeline stage and sets quant_bits to 12.
module quaternion_smallest_three_codec_top (
   input  logic        clock,
   input  logic        reset,
   qstc_req_if.sink    req_if,
   qstc_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import qstc_pkg::*;

   function automatic logic [16:0] mag16(logic signed [15:0] v);
      return v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
   endfunction

   logic adv;

   // configuration register
   logic [4:0] quant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff <= QUANT_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_QUANT_BITS) begin
         quant_ff <= pwdata[4:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_QUANT_BITS) ? {27'd0, quant_ff} : 32'd0;

   // global advance: the output register is empty or being taken
   logic out_valid_ff;
   assign adv          = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // stage 1: request capture
   logic               p1_valid_ff;
   logic               p1_op_ff;
   logic signed [15:0] p1_w_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_op_ff   <= req_if.opcode;
         p1_w_ff[0] <= req_if.in0;
         p1_w_ff[1] <= req_if.in1;
         p1_w_ff[2] <= req_if.in2;
         p1_w_ff[3] <= req_if.in3;
      end
   end

   // stage 1 logic: largest component, lane selection, signs
   qstc_ctrl_type      p2_ctrl_in, p2_ctrl_ff;
   logic [16:0]        p2_a_in [3];
   logic [16:0]        p2_a_ff [3];
   logic [2:0]         p2_neg_in, p2_neg_ff;
   logic [14:0]        p2_f_in, p2_f_ff;
   logic [15:0]        p2_as_in, p2_as_ff;
   logic [15:0]        p2_den_in, p2_den_ff;

   logic [16:0]        mag [4];
   logic [1:0]         qmax;
   logic               flip;
   logic [4:0]         nbits;
   logic [14:0]        s_val;
   logic signed [15:0] sf;
   logic [16:0]        sf_mag;
   logic [1:0]         src;
   logic               dec;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i] = mag16(p1_w_ff[i]);
      end
      qmax = 2'd0;
      for (int i = 1; i < 4; i++) begin
         if (mag[i] > mag[qmax]) begin
            qmax = 2'(i);
         end
      end
      flip = p1_w_ff[qmax][15];

      if (quant_ff < QUANT_MIN) begin
         nbits = QUANT_MIN;
      end else if (quant_ff > QUANT_MAX) begin
         nbits = QUANT_MAX;
      end else begin
         nbits = quant_ff;
      end
      s_val = 15'((16'd1 << (nbits - 5'd1)) - 16'd1);

      sf     = p1_w_ff[3] | SCALE_LOW_MASK;
      sf_mag = mag16(sf);
      dec    = (p1_op_ff == OP_DECODE);

      for (int k = 0; k < 3; k++) begin
         src = qmax + 2'(k + 1);
         if (dec) begin
            p2_a_in[k]   = mag[k];
            p2_neg_in[k] = (p1_w_ff[k][15] != sf[15]) && (p1_w_ff[k] != 16'sd0);
         end else begin
            p2_a_in[k]   = mag[src];
            p2_neg_in[k] = (p1_w_ff[src][15] != flip) && (p1_w_ff[src] != 16'sd0);
         end
      end

      p2_as_in         = sf_mag[15:0];
      p2_f_in          = dec ? SCALE_15 : s_val;
      p2_den_in        = dec ? p2_as_in : SCALE_16;
      p2_ctrl_in.valid = p1_valid_ff;
      p2_ctrl_in.op    = p1_op_ff;
      p2_ctrl_in.qc    = dec ? p1_w_ff[3][1:0] : qmax;
      p2_ctrl_in.s     = s_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         p2_ctrl_ff <= p2_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_a_ff   <= p2_a_in;
         p2_neg_ff <= p2_neg_in;
         p2_f_ff   <= p2_f_in;
         p2_as_ff  <= p2_as_in;
         p2_den_ff <= p2_den_in;
      end
   end

   // stage 2: scaled magnitudes and squares
   qstc_ctrl_type p3_ctrl_ff;
   logic [30:0]   p3_p_ff  [3];
   logic [30:0]   p3_a2_ff [3];
   logic [30:0]   p3_as2_ff;
   logic [2:0]    p3_neg_ff;
   logic [15:0]   p3_den_ff;
   logic [31:0]   prod_p  [3];
   logic [33:0]   prod_a2 [3];
   logic [31:0]   prod_as2;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_p[k]  = 32'(p2_a_ff[k]) * 32'(p2_f_ff);
         prod_a2[k] = 34'(p2_a_ff[k]) * 34'(p2_a_ff[k]);
      end
      prod_as2 = 32'(p2_as_ff) * 32'(p2_as_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         p3_ctrl_ff <= p2_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            p3_p_ff[k]  <= prod_p[k][30:0];
            p3_a2_ff[k] <= prod_a2[k][30:0];
         end
         p3_as2_ff <= prod_as2[30:0];
         p3_neg_ff <= p2_neg_ff;
         p3_den_ff <= p2_den_ff;
      end
   end

   // stage 3: squared products, residual for the missing component
   qstc_ctrl_type p4_ctrl_ff;
   logic [59:0]   p4_psq_ff [3];
   logic [30:0]   p4_diff_ff;
   logic [2:0]    p4_neg_ff;
   logic [15:0]   p4_den_ff;
   logic [30:0]   p4_d_ff;
   logic [61:0]   prod_psq [3];
   logic [32:0]   sumsq;
   logic [32:0]   d_val;
   logic [32:0]   diff_val;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_psq[k] = 62'(p3_p_ff[k]) * 62'(p3_p_ff[k]);
      end
      sumsq    = 33'(p3_a2_ff[0]) + 33'(p3_a2_ff[1]) + 33'(p3_a2_ff[2]);
      d_val    = {1'b0, p3_as2_ff, 1'b0};
      diff_val = (sumsq < d_val) ? (d_val - sumsq) : 33'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         p4_ctrl_ff <= p3_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            p4_psq_ff[k] <= prod_psq[k][59:0];
         end
         p4_diff_ff <= diff_val[30:0];
         p4_d_ff    <= d_val[30:0];
         p4_neg_ff  <= p3_neg_ff;
         p4_den_ff  <= p3_den_ff;
      end
   end

   // stage 4: radicands, first scale of the residual
   qstc_ctrl_type p5_ctrl_ff;
   logic [63:0]   p5_rad_ff [3];
   logic [45:0]   p5_t_ff;
   logic [30:0]   p5_d_ff;
   logic [2:0]    p5_neg_ff;
   logic [15:0]   p5_den_ff;
   logic [63:0]   rad_val [3];
   logic [45:0]   t_val;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rad_val[k] = (p4_ctrl_ff.op == OP_DECODE) ? {3'b000, p4_psq_ff[k], 1'b0}
                                                   : {1'b0, p4_psq_ff[k], 3'b000};
      end
      t_val = 46'(p4_diff_ff) * 46'(SCALE_15);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         p5_ctrl_ff <= p4_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_rad_ff <= rad_val;
         p5_t_ff   <= t_val;
         p5_d_ff   <= p4_d_ff;
         p5_neg_ff <= p4_neg_ff;
         p5_den_ff <= p4_den_ff;
      end
   end

   // stage 5: dividend for the missing component, 4 * K^2 * residual
   qstc_ctrl_type p6_ctrl_ff;
   logic [63:0]   p6_rad_ff [3];
   logic [62:0]   p6_num_ff;
   logic [30:0]   p6_d_ff;
   logic [2:0]    p6_neg_ff;
   logic [15:0]   p6_den_ff;
   logic [60:0]   n_val;

   assign n_val = 61'(p5_t_ff) * 61'(SCALE_15);

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         p6_ctrl_ff <= p5_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_rad_ff <= p5_rad_ff;
         p6_num_ff <= {n_val, 2'b00};
         p6_d_ff   <= p5_d_ff;
         p6_neg_ff <= p5_neg_ff;
         p6_den_ff <= p5_den_ff;
      end
   end

   // lane units: root of the radicand, then divide by the scale
   logic [31:0] lroot [3];
   logic [31:0] lquo  [3];
   logic [2:0]  lneg_mid;
   logic [2:0]  lneg;
   logic [15:0] lden;

   qstc_sqrt #(.RAD_W(64), .TAG_W(17)) u_lsqrt0 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .rad     (p6_rad_ff[0]),
      .tag_in  ({p6_neg_ff[0], p6_den_ff}),
      .root    (lroot[0]),
      .tag_out ({lneg_mid[0], lden})
   );

   for (genvar k = 1; k < 3; k++) begin : g_lsqrt
      qstc_sqrt #(.RAD_W(64), .TAG_W(1)) u_lsqrt (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .rad     (p6_rad_ff[k]),
         .tag_in  (p6_neg_ff[k]),
         .root    (lroot[k]),
         .tag_out (lneg_mid[k])
      );
   end

   for (genvar k = 0; k < 3; k++) begin : g_ldiv
      qstc_div #(.QUO_W(32), .DEN_W(16), .TAG_W(1)) u_ldiv (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .num     ({16'd0, lroot[k]}),
         .den     (lden),
         .tag_in  (lneg_mid[k]),
         .quo     (lquo[k]),
         .tag_out (lneg[k])
      );
   end

   // missing component: divide by 2*sf^2, then root
   logic [31:0]   wquo;
   logic [63:0]   wroot;
   qstc_ctrl_type wctrl_mid;
   qstc_ctrl_type fctrl;

   qstc_div #(.QUO_W(32), .DEN_W(31), .TAG_W(CTRL_W)) u_wdiv (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .num     (p6_num_ff),
      .den     (p6_d_ff),
      .tag_in  (p6_ctrl_ff),
      .quo     (wquo),
      .tag_out (wctrl_mid)
   );

   // radicand padded by 2^32 so the unit depth matches the lane dividers
   qstc_sqrt #(.RAD_W(64), .TAG_W(CTRL_W)) u_wsqrt (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .rad     ({wquo, 32'd0}),
      .tag_in  (wctrl_mid),
      .root    (wroot[31:0]),
      .tag_out (fctrl)
   );
   assign wroot[63:32] = '0;

   // rounding, clamping, sign and reordering into the response
   logic [15:0] out_in [4];
   logic [15:0] out_ff [4];
   logic        out_op_ff;
   logic [32:0] q_full;
   logic [31:0] q_val;
   logic [14:0] q_enc;
   logic [15:0] q_mag;
   logic [16:0] wf;
   logic [15:0] dec_w [4];

   always_comb begin
      wf = (17'(wroot[31:16]) + 17'd1) >> 1;
      dec_w[fctrl.qc] = wf[15:0];
      for (int k = 0; k < 4; k++) begin
         out_in[k] = 16'd0;
         dec_w[k]  = (k == 32'(fctrl.qc)) ? wf[15:0] : 16'd0;
      end
      for (int k = 0; k < 3; k++) begin
         q_full = (33'(lquo[k]) + 33'd1) >> 1;
         q_val  = q_full[31:0];
         q_enc  = (q_val > 32'(fctrl.s)) ? fctrl.s : q_val[14:0];
         if (fctrl.op == OP_DECODE) begin
            q_mag = q_val[15:0];
            dec_w[fctrl.qc + 2'(k + 1)] = lneg[k] ? (16'd0 - q_mag) : q_mag;
         end else begin
            q_mag     = {1'b0, q_enc};
            out_in[k] = lneg[k] ? (16'd0 - q_mag) : q_mag;
         end
      end
      if (fctrl.op == OP_DECODE) begin
         out_in = dec_w;
      end else begin
         out_in[3] = {1'b0, fctrl.s[14:8], 6'd0, fctrl.qc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= fctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff    <= out_in;
         out_op_ff <= fctrl.op;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.out0  = out_ff[0];
   assign rsp_if.out1  = out_ff[1];
   assign rsp_if.out2  = out_ff[2];
   assign rsp_if.out3  = out_ff[3];

   // checks on pipeline control and the packed index word
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> p1_valid_ff)
      else $error("accepted request did not enter the first stage");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !out_valid_ff && !p1_valid_ff)
      else $error("pipeline not empty after reset");

   a_encode_index_word : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_op_ff == OP_ENCODE |-> out_ff[3][7:2] == 6'd0)
      else $error("encode index word has stray low bits");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(p6_ctrl_ff) && $stable(fctrl))
      else $error("pipeline moved during a stall");

endmodule
